### rtl/assert_macros.svh
// Assertion macros for the decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define U8L9_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define U8L9_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/u8l9_pkg.sv
// Shared types and helper functions of the UTF-8 decoder with Latin-9 fallback.
// No dependencies; used by the front, queue, back and top modules.
package u8l9_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IDX_W = 2;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            from_fallback;
  } result_t;

  // One queued job: all results that a single accepted byte causes.
  typedef struct packed {
    logic [RES_IDX_W-1:0] last_idx;
    result_t [MAX_RES-1:0] res;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  function automatic logic [CP_W-1:0] latin9_map(input logic [BYTE_W-1:0] b);
    logic [CP_W-1:0] cp;
    case (b)
      8'hA4:   cp = 21'h020AC;
      8'hA6:   cp = 21'h00160;
      8'hA8:   cp = 21'h00161;
      8'hB4:   cp = 21'h0017D;
      8'hB8:   cp = 21'h0017E;
      8'hBC:   cp = 21'h00152;
      8'hBD:   cp = 21'h00153;
      8'hBE:   cp = 21'h00178;
      default: cp = {13'd0, b};
    endcase
    return cp;
  endfunction

  // Continuation bytes a lead byte asks for; zero if it is not a lead byte.
  function automatic logic [1:0] lead_needs(input logic [BYTE_W-1:0] b);
    logic [1:0] n;
    if (b[7:5] == 3'b110) begin
      n = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      n = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      n = 2'd3;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

### rtl/u8l9_front.sv
// Front part: takes bytes, keeps the pending sequence and builds at most one job per byte.
// Depends on u8l9_pkg.
module u8l9_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [u8l9_pkg::BYTE_W-1:0]  byte_value,
  input  logic                         end_of_buffer,
  output logic                         push,
  output u8l9_pkg::job_t               job
);

  logic [u8l9_pkg::BYTE_W-1:0] held_lead;
  logic [1:0]                  held_count;
  logic [u8l9_pkg::BYTE_W-1:0] held_cont [3];

  logic [u8l9_pkg::BYTE_W-1:0] held_lead_next;
  logic [1:0]                  held_count_next;
  logic                        cont_we;

  logic [u8l9_pkg::BYTE_W-1:0] seq_bytes [4];
  logic [1:0]                  need;
  logic [2:0]                  k_plus1;
  logic                        is_cont;
  logic                        fresh_emit;
  logic                        fresh_hold;
  u8l9_pkg::result_t           fresh_res;
  logic                        decoded_en;
  logic [u8l9_pkg::CP_W-1:0]   decoded;
  logic [2:0]                  n_flush;
  logic                        tail_en;
  logic [2:0]                  n_res;

  always_comb begin
    need    = u8l9_pkg::lead_needs(held_lead);
    k_plus1 = {1'b0, held_count} + 3'd1;
    is_cont = (byte_value[7:6] == 2'b10);

    // The held sequence as it stands once the current byte is added to it.
    seq_bytes[0] = held_lead;
    seq_bytes[1] = held_cont[0];
    seq_bytes[2] = held_cont[1];
    seq_bytes[3] = held_cont[2];
    seq_bytes[k_plus1[1:0]] = byte_value;

    // A byte decoded as if nothing were pending.
    fresh_emit = 1'b1;
    fresh_hold = 1'b0;
    if (!byte_value[7]) begin
      fresh_res = '{code_point: {13'd0, byte_value}, from_fallback: 1'b0};
    end else if (u8l9_pkg::lead_needs(byte_value) != 2'd0 && !end_of_buffer) begin
      fresh_res  = '{code_point: '0, from_fallback: 1'b0};
      fresh_emit = 1'b0;
      fresh_hold = 1'b1;
    end else begin
      fresh_res = '{code_point: u8l9_pkg::latin9_map(byte_value), from_fallback: 1'b1};
    end

    case (need)
      2'd1:    decoded = {10'd0, held_lead[4:0], seq_bytes[1][5:0]};
      2'd2:    decoded = {5'd0, held_lead[3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
      2'd3:    decoded = {held_lead[2:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                          seq_bytes[3][5:0]};
      default: decoded = '0;
    endcase
  end

  always_comb begin
    decoded_en      = 1'b0;
    n_flush         = 3'd0;
    tail_en         = 1'b0;
    cont_we         = 1'b0;
    held_lead_next  = held_lead;
    held_count_next = held_count;
    if (held_lead == '0) begin
      tail_en = fresh_emit;
      if (fresh_hold) begin
        held_lead_next  = byte_value;
        held_count_next = 2'd0;
      end
    end else if (is_cont) begin
      cont_we = 1'b1;
      if (k_plus1[1:0] == need) begin
        decoded_en      = 1'b1;
        held_lead_next  = '0;
        held_count_next = 2'd0;
      end else if (end_of_buffer) begin
        // The buffer ends inside a sequence: lead, held bytes and this one fall back.
        n_flush         = k_plus1 + 3'd1;
        held_lead_next  = '0;
        held_count_next = 2'd0;
      end else begin
        held_count_next = k_plus1[1:0];
      end
    end else begin
      n_flush         = k_plus1;
      tail_en         = fresh_emit;
      held_lead_next  = fresh_hold ? byte_value : '0;
      held_count_next = 2'd0;
    end
  end

  always_comb begin
    n_res = decoded_en ? 3'd1 : (n_flush + {2'd0, tail_en});
    push  = accept && (n_res != 3'd0);
    job.last_idx = n_res[1:0] - 2'd1;
    for (int i = 0; i < 4; i++) begin
      if (decoded_en) begin
        job.res[i] = '{code_point: decoded, from_fallback: 1'b0};
      end else if (3'(i) < n_flush) begin
        job.res[i] = '{code_point: u8l9_pkg::latin9_map(seq_bytes[i]), from_fallback: 1'b1};
      end else begin
        job.res[i] = fresh_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead  <= '0;
      held_count <= 2'd0;
    end else if (accept) begin
      held_lead  <= held_lead_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cont_we) begin
      held_cont[held_count] <= byte_value;
    end
  end

endmodule

### rtl/u8l9_queue.sv
// Short job queue between the front and back parts.
// Depends on u8l9_pkg; DEPTH must be at least 2.
module u8l9_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u8l9_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output u8l9_pkg::job_t pop_data,
  output logic           empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8l9_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/u8l9_back.sv
// Back part: loads one job at a time and sends its results one per cycle while out_ready is high.
// Depends on u8l9_pkg.
module u8l9_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  u8l9_pkg::job_t              q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output u8l9_pkg::result_t           out_res,
  output logic                        out_last
);

  u8l9_pkg::job_t                   cur;
  logic [u8l9_pkg::RES_IDX_W-1:0]   idx;
  logic                             busy;
  logic                             take;

  always_comb begin
    out_valid = busy;
    out_res   = cur.res[idx];
    out_last  = (idx == cur.last_idx);
    // A new job is loaded when idle or as the final result of the current one leaves.
    take      = !busy || (out_ready && out_last);
    q_pop     = take && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= !q_empty;
      idx  <= '0;
    end else if (out_ready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule

### rtl/utf8_decoder_latin9_fallback_top.sv
// UTF-8 decoder with Latin-9 fallback: one byte per input item, code points out.
// A byte is taken every cycle while the job queue has room; its results pass the
// queue slot and the back part's job register. Results leave at one per cycle while
// m_tready is high; a byte causes up to four results (on a fallback flush).
// Synchronous active-high reset drops any pending sequence, empties the queue and
// clears the output valid.
`include "assert_macros.svh"

module utf8_decoder_latin9_fallback_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // end_of_buffer
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // from_fallback
  output logic        m_tlast    // last_of_run
);

  logic              accept;
  logic              push;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  u8l9_pkg::job_t    push_job;
  u8l9_pkg::job_t    head_job;
  u8l9_pkg::result_t out_res;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  u8l9_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_value    (s_tdata),
    .end_of_buffer (s_tlast),
    .push          (push),
    .job           (push_job)
  );

  u8l9_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_job),
    .empty     (q_empty)
  );

  u8l9_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (head_job),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'd0, out_res.code_point};
  assign m_tuser = out_res.from_fallback;

  `U8L9_ASSERT(a_push_room, clk, rst, push |-> !q_full, "job pushed into a full queue")
  `U8L9_ASSERT(a_pop_data, clk, rst, q_pop |-> !q_empty, "job popped from an empty queue")
  `U8L9_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

### tb/tb_utf8_decoder_latin9_fallback_top.sv
// Self-checking testbench for the UTF-8 decoder with Latin-9 fallback.
// Drives bytes under random idling on both streams and checks every code point
// against a predictor kept in step with the input. Depends on u8l9_pkg and the top.
module tb_utf8_decoder_latin9_fallback_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] value;
    logic       eob;
  } byte_item_t;

  typedef struct {
    logic [u8l9_pkg::CP_W-1:0] cp;
    logic                      fallback;
    logic                      ends_run;
  } cp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] byte_value
  logic        s_tlast = 1'b0;   // end_of_buffer
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [20:0] code_point, [23:21] zero
  logic        m_tuser;          // from_fallback
  logic        m_tlast;          // last_of_run

  byte_item_t byte_pending[$];
  cp_result_t cp_expected[$];
  cp_result_t step_results[$];

  // Predictor state: the pending lead byte (zero when none) and its continuations.
  logic [7:0] pend_lead = 8'd0;
  logic [7:0] pend_cont[3];
  int         pend_cnt = 0;

  int  n_bytes_in = 0;
  int  n_err = 0;
  bit  took = 1'b0;
  int  phase;

  utf8_decoder_latin9_fallback_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [u8l9_pkg::CP_W-1:0] to_latin9(input logic [7:0] b);
    case (b)
      8'hA4:   return 21'h020AC;
      8'hA6:   return 21'h00160;
      8'hA8:   return 21'h00161;
      8'hB4:   return 21'h0017D;
      8'hB8:   return 21'h0017E;
      8'hBC:   return 21'h00152;
      8'hBD:   return 21'h00153;
      8'hBE:   return 21'h00178;
      default: return {13'd0, b};
    endcase
  endfunction

  function automatic int cont_needed(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 1;
    if (b[7:4] == 4'b1110) return 2;
    if (b[7:3] == 5'b11110) return 3;
    return 0;
  endfunction

  task emit(input logic [u8l9_pkg::CP_W-1:0] cp, input logic fallback);
    cp_result_t r;
    r.cp = cp;
    r.fallback = fallback;
    r.ends_run = 1'b0;
    step_results.push_back(r);
  endtask

  task flush_pending();
    emit(to_latin9(pend_lead), 1'b1);
    for (int i = 0; i < pend_cnt; i++) emit(to_latin9(pend_cont[i]), 1'b1);
    pend_lead = 8'd0;
    pend_cnt = 0;
  endtask

  task start_byte(input logic [7:0] b, input logic eob);
    if (!b[7]) begin
      emit({13'd0, b}, 1'b0);
    end else if (cont_needed(b) != 0 && !eob) begin
      pend_lead = b;
      pend_cnt = 0;
    end else begin
      emit(to_latin9(b), 1'b1);
    end
  endtask

  task predict_byte(input logic [7:0] b, input logic eob);
    logic [u8l9_pkg::CP_W-1:0] cp;
    int need;
    step_results.delete();
    if (pend_lead == 8'd0) begin
      start_byte(b, eob);
    end else if (b[7:6] == 2'b10) begin
      need = cont_needed(pend_lead);
      pend_cont[pend_cnt] = b;
      pend_cnt++;
      if (pend_cnt == need) begin
        case (need)
          1:       cp = {10'd0, pend_lead[4:0], pend_cont[0][5:0]};
          2:       cp = {5'd0, pend_lead[3:0], pend_cont[0][5:0], pend_cont[1][5:0]};
          default: cp = {pend_lead[2:0], pend_cont[0][5:0], pend_cont[1][5:0],
                         pend_cont[2][5:0]};
        endcase
        emit(cp, 1'b0);
        pend_lead = 8'd0;
        pend_cnt = 0;
      end else if (eob) begin
        flush_pending();
      end
    end else begin
      flush_pending();
      start_byte(b, eob);
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].ends_run = 1'b1;
    foreach (step_results[i]) cp_expected.push_back(step_results[i]);
  endtask

  // Input acceptance feeds the predictor; output acceptance is checked in order.
  always @(posedge clk) begin
    cp_result_t want;
    took = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      predict_byte(s_tdata, s_tlast);
      n_bytes_in++;
      took = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (cp_expected.size() == 0) begin
        $error("unexpected result: code_point %h from_fallback %b last_of_run %b",
               m_tdata[20:0], m_tuser, m_tlast);
        n_err++;
      end else begin
        want = cp_expected.pop_front();
        if (m_tdata[20:0] !== want.cp) begin
          $error("code_point: expected %h, got %h", want.cp, m_tdata[20:0]);
          n_err++;
        end
        if (m_tdata[23:21] !== 3'd0) begin
          $error("tdata padding: expected %h, got %h", 3'd0, m_tdata[23:21]);
          n_err++;
        end
        if (m_tuser !== want.fallback) begin
          $error("from_fallback: expected %b, got %b", want.fallback, m_tuser);
          n_err++;
        end
        if (m_tlast !== want.ends_run) begin
          $error("last_of_run: expected %b, got %b", want.ends_run, m_tlast);
          n_err++;
        end
      end
    end
  end

  // Idling rotates every 40 accepted bytes: none, sender gaps, receiver stalls, both.
  assign phase = (n_bytes_in / 40) % 4;

  always @(negedge clk) begin
    byte_item_t it;
    bit tx_idle;
    bit rx_stall;
    tx_idle = (phase == 1) ? ($urandom_range(0, 99) < 54) :
              (phase == 3) ? ($urandom_range(0, 99) < 13) : 1'b0;
    rx_stall = (phase == 2) ? ($urandom_range(0, 99) < 54) :
               (phase == 3) ? ($urandom_range(0, 99) < 13) : 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_stall;
      if (!s_tvalid || took) begin
        if (byte_pending.size() > 0 && !tx_idle) begin
          it = byte_pending.pop_front();
          s_tdata <= it.value;
          s_tlast <= it.eob;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task add_byte(input logic [7:0] value, input logic eob);
    byte_item_t it;
    it.value = value;
    it.eob = eob;
    byte_pending.push_back(it);
  endtask

  function automatic logic [7:0] rand_lead(input int need);
    logic [7:0] r;
    r = 8'($urandom);
    case (need)
      1:       return {3'b110, r[4:0]};
      2:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // Lead plus continuations; a short count leaves the sequence open for a breaker.
  task add_sequence(input int need, input int conts, input logic eob_on_tail);
    add_byte(rand_lead(need), eob_on_tail && conts == 0);
    for (int i = 0; i < conts; i++) add_byte(rand_cont(), eob_on_tail && i == conts - 1);
  endtask

  initial begin
    int kind;
    int need;
    int k;
    logic [7:0] r;

    // Directed: extremes, strays, Latin-9 remap, every sequence length, and the
    // lead-on-final-byte, broken-sequence and early-end flush paths.
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hA4, 1'b0);
    add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b1);
    add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hC3, 1'b1);
    add_byte(8'hE2, 1'b0); add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b1);

    k = byte_pending.size();
    while (byte_pending.size() - k < 330) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        r = 8'($urandom);
        add_byte({1'b0, r[6:0]}, $urandom_range(0, 9) == 0);
      end else if (kind < 60) begin
        need = (kind < 30) ? 1 : (kind < 45) ? 2 : 3;
        add_sequence(need, need, $urandom_range(0, 3) == 0);
      end else if (kind < 75) begin
        need = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1) begin
          add_sequence(need, $urandom_range(0, need - 1), 1'b1);
        end else begin
          add_sequence(need, $urandom_range(0, need - 1), 1'b0);
          r = 8'($urandom);
          if (r[7:6] == 2'b10) r[6] = 1'b0;
          add_byte(r, $urandom_range(0, 4) == 0);
        end
      end else if (kind < 88) begin
        add_byte(8'($urandom), $urandom_range(0, 6) == 0);
      end else begin
        r = 8'($urandom);
        add_byte(r[6] ? {5'b11111, r[2:0]} : {2'b10, r[5:0]}, $urandom_range(0, 4) == 0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_pending.size() != 0 || s_tvalid) @(posedge clk);
    while (cp_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_utf8_decoder_latin9_fallback_top: done, clean");
    end else begin
      $display("tb_utf8_decoder_latin9_fallback_top: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_utf8_decoder_latin9_fallback_top: done, errors");
    $finish;
  end

endmodule
